// ===== hdl/bsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the buffer slot allocator.
// No dependencies; every other file imports this package.
package bsa_pkg;

	localparam int SLOTS     = 4;
	localparam int MAX_BYTES = 65536;

	localparam int SLOT_IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LEN_W     = 17;
	localparam int LEN_LIM   = (MAX_BYTES > 131071) ? 131071 : MAX_BYTES;

	localparam logic [2:0] OP_ALLOC     = 3'd0;
	localparam logic [2:0] OP_MARK_WR   = 3'd1;
	localparam logic [2:0] OP_RELEASE   = 3'd2;
	localparam logic [2:0] OP_QUERY     = 3'd3;
	localparam logic [2:0] OP_FIND_WR   = 3'd4;
	localparam logic [2:0] OP_RESET_ALL = 3'd5;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_RANGE = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;
	localparam logic [1:0] ERR_STATE = 2'd3;

	typedef enum logic [1:0] {
		ST_FREE    = 2'd0,
		ST_BUSY    = 2'd1,
		ST_WRITTEN = 2'd2
	} slot_st_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [5:0]  slot_select;
		logic [19:0] request_size;
	} req_t;

	typedef struct packed {
		logic [5:0]       slot_index;
		logic             found;
		logic [1:0]       slot_state;
		logic [LEN_W-1:0] slot_bytes;
		logic [1:0]       error_code;
	} rsp_t;

endpackage

// ===== hdl/bsa_in_stage.sv =====
`timescale 1ns / 1ps
// Input register stage: captures one request transaction per cycle while req_stall is low.
// Depends on bsa_pkg.
module bsa_in_stage
	import bsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	input  logic advance,
	output logic valid_s1,
	output req_t req_s1
);

	logic load;

	assign req_stall = valid_s1 && !advance;
	assign load      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_s1 <= req;
		end
	end

endmodule

// ===== hdl/bsa_slot_engine.sv =====
`timescale 1ns / 1ps
// Slot status and size store plus the single-pass operation logic.
// Depends on bsa_pkg.
module bsa_slot_engine
	import bsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  req_t req_s1,
	output rsp_t result
);

	slot_st_t               status_q [SLOTS];
	slot_st_t               status_d [SLOTS];
	logic [LEN_W-1:0]       len_q    [SLOTS];
	logic                   len_we;
	logic [LEN_W-1:0]       len_clamped;
	logic                   free_found;
	logic [SLOT_IW-1:0]     free_idx;
	logic                   wr_found;
	logic [SLOT_IW-1:0]     wr_idx;
	logic                   sel_ok;
	logic [SLOT_IW-1:0]     sel_i;

	assign sel_ok = {1'b0, req_s1.slot_select} < 7'(SLOTS);
	assign sel_i  = req_s1.slot_select[SLOT_IW-1:0];

	assign len_clamped = (req_s1.request_size > 20'(LEN_LIM)) ? LEN_W'(LEN_LIM)
		: req_s1.request_size[LEN_W-1:0];

	// lowest free and lowest written slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		wr_found   = 1'b0;
		wr_idx     = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (status_q[k] == ST_FREE) begin
				free_found = 1'b1;
				free_idx   = SLOT_IW'(k);
			end
			if (status_q[k] == ST_WRITTEN) begin
				wr_found = 1'b1;
				wr_idx   = SLOT_IW'(k);
			end
		end
	end

	always_comb begin
		result   = '0;
		len_we   = 1'b0;
		status_d = status_q;
		case (req_s1.operation)
			OP_ALLOC: begin
				if (free_found) begin
					status_d[free_idx] = ST_BUSY;
					len_we             = 1'b1;
					result.slot_index  = 6'(free_idx);
					result.found       = 1'b1;
					result.slot_state  = ST_BUSY;
					result.slot_bytes  = len_clamped;
				end else begin
					result.error_code = ERR_FULL;
				end
			end
			OP_MARK_WR: begin
				if (!sel_ok) begin
					result.error_code = ERR_RANGE;
				end else if (status_q[sel_i] != ST_BUSY) begin
					result.error_code = ERR_STATE;
				end else begin
					status_d[sel_i] = ST_WRITTEN;
				end
			end
			OP_RELEASE: begin
				if (!sel_ok) begin
					result.error_code = ERR_RANGE;
				end else if (status_q[sel_i] != ST_WRITTEN) begin
					result.error_code = ERR_STATE;
				end else begin
					status_d[sel_i] = ST_FREE;
				end
			end
			OP_QUERY: begin
				if (!sel_ok) begin
					result.error_code = ERR_RANGE;
				end else begin
					result.slot_state = status_q[sel_i];
					result.slot_bytes = len_q[sel_i];
				end
			end
			OP_FIND_WR: begin
				if (wr_found) begin
					result.slot_index = 6'(wr_idx);
					result.found      = 1'b1;
				end
			end
			OP_RESET_ALL: begin
				for (int k = 0; k < SLOTS; k++) begin
					status_d[k] = ST_FREE;
				end
			end
			default: begin
			end
		endcase
	end

	// commit state only when the transaction moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				status_q[k] <= ST_FREE;
			end
		end else if (advance) begin
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && len_we) begin
			len_q[free_idx] <= len_clamped;
		end
	end

endmodule

// ===== hdl/bsa_out_stage.sv =====
`timescale 1ns / 1ps
// Result register: holds one response transaction until the sink takes it.
// Depends on bsa_pkg.
module bsa_out_stage
	import bsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  rsp_t result,
	output logic advance,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic rsp_valid_q;
	rsp_t rsp_q;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

endmodule

// ===== hdl/buffer_slot_allocator_top.sv =====
`timescale 1ns / 1ps
// Buffer slot allocator: a request transaction passes the input register, then the
// result register. Throughput one transaction per cycle unless rsp_stall holds it;
// the slot table is read and updated between those two registers.
// arst_n clears both pipeline valids and marks every slot free; stored sizes
// are not cleared and hold no meaning until an allocate writes them.
// Depends on bsa_pkg, bsa_in_stage, bsa_slot_engine, bsa_out_stage.
module buffer_slot_allocator_top
	import bsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic advance;
	logic valid_s1;
	req_t req_s1;
	rsp_t result;

	bsa_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1)
	);

	bsa_slot_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req_s1  (req_s1),
		.result  (result)
	);

	bsa_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.advance   (advance),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== hdl/bsa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the buffer slot allocator, bound to the top level.
// Depends on bsa_pkg and buffer_slot_allocator_top.
module bsa_checker
	import bsa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a full request side only comes from a stalled response
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("request stall without a stalled response");

	// a failed operation reports nothing but its code
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.error_code != ERR_OK) |->
		(!rsp.found && rsp.slot_index == 6'd0 && rsp.slot_state == 2'd0
		&& rsp.slot_bytes == '0))
		else $error("error response carries data");

	// a located slot lies inside the pool
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |-> ({1'b0, rsp.slot_index} < 7'(SLOTS)))
		else $error("found slot outside the pool");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response dropped or changed");

endmodule

bind buffer_slot_allocator_top bsa_checker u_bsa_checker (.*);

// ===== tb/sv/buffer_slot_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for buffer_slot_allocator_top: directed and random slot operations,
// a slot-pool predictor and an in-order response check under random idling and stalls.
// Depends on bsa_pkg and the buffer_slot_allocator_top RTL.
module buffer_slot_allocator_top_tb;
	import bsa_pkg::*;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Predicted pool contents, updated as each request transaction is accepted.
	slot_st_t         pool_state [SLOTS];
	logic [LEN_W-1:0] pool_bytes [SLOTS];
	bit               pool_sized [SLOTS];
	rsp_t             pending_rsp [$];

	int mismatches = 0;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int holdoff_len = 0;
	int stall_hold = 0;
	int quiet_cycles = 0;

	buffer_slot_allocator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int lowest_slot(slot_st_t s);
		for (int k = 0; k < SLOTS; k++) begin
			if (pool_state[k] == s) return k;
		end
		return -1;
	endfunction

	function automatic int pick_slot(slot_st_t s);
		int hits [$];
		for (int k = 0; k < SLOTS; k++) begin
			if (pool_state[k] == s) hits.push_back(k);
		end
		if (hits.size() == 0) return -1;
		return hits[$urandom_range(hits.size() - 1)];
	endfunction

	// Apply one operation to the predicted pool and return the response it gives.
	function automatic rsp_t apply_slot_op(req_t r);
		rsp_t o;
		int   k;
		int   sel;
		o = '0;
		sel = int'(r.slot_select);
		case (r.operation)
			OP_ALLOC: begin
				k = lowest_slot(ST_FREE);
				if (k < 0) begin
					o.error_code = ERR_FULL;
				end else begin
					pool_state[k] = ST_BUSY;
					pool_bytes[k] = (int'(r.request_size) > LEN_LIM) ?
						LEN_W'(LEN_LIM) : LEN_W'(r.request_size);
					pool_sized[k] = 1'b1;
					o.slot_index = 6'(k);
					o.found = 1'b1;
					o.slot_state = ST_BUSY;
					o.slot_bytes = pool_bytes[k];
				end
			end
			OP_MARK_WR: begin
				if (sel >= SLOTS) o.error_code = ERR_RANGE;
				else if (pool_state[sel] != ST_BUSY) o.error_code = ERR_STATE;
				else pool_state[sel] = ST_WRITTEN;
			end
			OP_RELEASE: begin
				if (sel >= SLOTS) o.error_code = ERR_RANGE;
				else if (pool_state[sel] != ST_WRITTEN) o.error_code = ERR_STATE;
				else pool_state[sel] = ST_FREE;
			end
			OP_QUERY: begin
				if (sel >= SLOTS) begin
					o.error_code = ERR_RANGE;
				end else begin
					o.slot_state = pool_state[sel];
					o.slot_bytes = pool_bytes[sel];
				end
			end
			OP_FIND_WR: begin
				k = lowest_slot(ST_WRITTEN);
				if (k >= 0) begin
					o.slot_index = 6'(k);
					o.found = 1'b1;
				end
			end
			OP_RESET_ALL: begin
				for (int j = 0; j < SLOTS; j++) pool_state[j] = ST_FREE;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic req_t slot_op(logic [2:0] op, int sel, int size);
		req_t r;
		r.operation = op;
		r.slot_select = 6'(sel);
		r.request_size = 20'(size);
		return r;
	endfunction

	function automatic logic [19:0] gen_size();
		case ($urandom_range(3))
			0: return 20'($urandom);
			1: return 20'($urandom_range(255));
			2: return 20'(LEN_LIM - 1 + $urandom_range(2));
			default: return 20'hFFFFF;
		endcase
	endfunction

	// Mostly well-formed operations on slots in a matching state, plus some noise.
	function automatic req_t gen_slot_op();
		req_t r;
		int   roll;
		int   s;
		r.slot_select = 6'($urandom_range(63));
		r.request_size = gen_size();
		roll = $urandom_range(99);
		if (roll < 25) begin
			r.operation = OP_ALLOC;
		end else if (roll < 45) begin
			r.operation = OP_MARK_WR;
			s = pick_slot(ST_BUSY);
			if (s >= 0 && $urandom_range(9) < 8) r.slot_select = 6'(s);
		end else if (roll < 65) begin
			r.operation = OP_RELEASE;
			s = pick_slot(ST_WRITTEN);
			if (s >= 0 && $urandom_range(9) < 8) r.slot_select = 6'(s);
		end else if (roll < 80) begin
			r.operation = OP_QUERY;
			if ($urandom_range(9) < 8) r.slot_select = 6'($urandom_range(SLOTS - 1));
		end else if (roll < 90) begin
			r.operation = OP_FIND_WR;
		end else if (roll < 95) begin
			r.operation = OP_RESET_ALL;
		end else if (roll < 97) begin
			r.operation = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
		end else begin
			r = req_t'($urandom);
		end
		return r;
	endfunction

	// Offer one transaction; valid stays high afterwards so the next one follows
	// without a bubble unless an idle gap is drawn.
	task automatic send_slot_op(req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		// Sizes are undefined until allocated: turn such a query into a search.
		if (item.operation == OP_QUERY && int'(item.slot_select) < SLOTS &&
		    !pool_sized[item.slot_select[SLOT_IW-1:0]])
			item.operation = OP_FIND_WR;
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_rsp.push_back(apply_slot_op(item));
	endtask

	task automatic test_directed();
		send_slot_op(slot_op(OP_FIND_WR, 0, 0));
		send_slot_op(slot_op(OP_QUERY, 63, 0));
		send_slot_op(slot_op(OP_QUERY, SLOTS, 0));
		send_slot_op(slot_op(OP_MARK_WR, 0, 0));
		send_slot_op(slot_op(OP_RELEASE, 0, 0));
		send_slot_op(slot_op(OP_MARK_WR, 63, 0));
		send_slot_op(slot_op(OP_RELEASE, 63, 0));
		for (int k = 0; k < SLOTS; k++) begin
			case (k % 4)
				0: send_slot_op(slot_op(OP_ALLOC, 0, 0));
				1: send_slot_op(slot_op(OP_ALLOC, 0, 20'hFFFFF));
				2: send_slot_op(slot_op(OP_ALLOC, 0, LEN_LIM));
				default: send_slot_op(slot_op(OP_ALLOC, 0, LEN_LIM + 1));
			endcase
		end
		send_slot_op(slot_op(OP_ALLOC, 0, 100));
		send_slot_op(slot_op(OP_QUERY, 0, 0));
		send_slot_op(slot_op(OP_QUERY, SLOTS - 1, 0));
		send_slot_op(slot_op(OP_MARK_WR, 0, 0));
		send_slot_op(slot_op(OP_MARK_WR, 0, 0));
		send_slot_op(slot_op(OP_RELEASE, SLOTS - 1, 0));
		send_slot_op(slot_op(OP_FIND_WR, 0, 0));
		send_slot_op(slot_op(OP_RELEASE, 0, 0));
		send_slot_op(slot_op(OP_QUERY, 0, 0));
		send_slot_op(slot_op(OP_SPARE_A, 1, 20'hFFFFF));
		send_slot_op(slot_op(OP_SPARE_B, 63, 20'h55555));
		send_slot_op(slot_op(OP_RESET_ALL, 0, 0));
		send_slot_op(slot_op(OP_QUERY, SLOTS - 1, 0));
		send_slot_op(slot_op(OP_FIND_WR, 0, 0));
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (count) send_slot_op(gen_slot_op());
	endtask

	// Hold responses off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		holdoff_len = HOLDOFF_CYCLES;
		repeat (30) send_slot_op(gen_slot_op());
	endtask

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			rsp_stall <= 1'b1;
		end else if (holdoff_len > 0) begin
			stall_hold <= holdoff_len;
			holdoff_len = 0;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("response with no request outstanding: %p", rsp);
				mismatches++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.slot_index !== want.slot_index) begin
					$error("slot_index: expected %0d, got %0d", want.slot_index, rsp.slot_index);
					mismatches++;
				end
				if (rsp.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, rsp.found);
					mismatches++;
				end
				if (rsp.slot_state !== want.slot_state) begin
					$error("slot_state: expected %0d, got %0d", want.slot_state, rsp.slot_state);
					mismatches++;
				end
				if (rsp.slot_bytes !== want.slot_bytes) begin
					$error("slot_bytes: expected %0d, got %0d", want.slot_bytes, rsp.slot_bytes);
					mismatches++;
				end
				if (rsp.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code, rsp.error_code);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < SLOTS; k++) begin
			pool_state[k] = ST_FREE;
			pool_bytes[k] = '0;
			pool_sized[k] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(90, 0, 0);
		test_random(90, 50, 0);
		test_random(90, 0, 50);
		test_backpressure();
		test_random(90, 23, 23);

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/bsa_pkg.sv
hdl/bsa_in_stage.sv
hdl/bsa_slot_engine.sv
hdl/bsa_out_stage.sv
hdl/buffer_slot_allocator_top.sv
hdl/bsa_checker.sv
tb/sv/buffer_slot_allocator_top_tb.sv
